// ===== design/tabs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tabs_pkg;

    localparam int MAX_BREAKPOINTS_DEF = 32;
    localparam int CNT_W  = 6;
    localparam int IDX_W  = 5;
    localparam int POS_W  = 5;
    localparam int F_W    = 32;

    // request and register codes
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_LOOKUP  = 1'b1;
    localparam logic AXIS_X      = 1'b0;
    localparam logic AXIS_Y      = 1'b1;
    localparam logic CFG_X_COUNT = 1'b0;
    localparam logic CFG_Y_COUNT = 1'b1;

    // arithmetic unit operations
    localparam logic OP_SUB = 1'b0;
    localparam logic OP_DIV = 1'b1;

    localparam logic [F_W-1:0] QNAN = 32'h7FC0_0000;

    typedef struct packed {
        logic             start;
        logic             op;
        logic [F_W-1:0]   a;
        logic [F_W-1:0]   b;
    } t_fpu_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] index;
        logic [F_W-1:0]   fraction;
    } t_lane_res;

    function automatic logic f_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    // map a float onto an unsigned key that orders like the value
    function automatic logic [31:0] f_key(input logic [31:0] x);
        return x[31] ? ~x : {1'b1, x[30:0]};
    endfunction

    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        logic zz;
        zz = ((a[30:0] | b[30:0]) == 31'd0);
        return !f_nan(a) && !f_nan(b) && !zz && (f_key(a) < f_key(b));
    endfunction

    function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
        logic zz;
        zz = ((a[30:0] | b[30:0]) == 31'd0);
        return !f_nan(a) && !f_nan(b) && (zz || (f_key(a) <= f_key(b)));
    endfunction

    // shift right, folding lost bits into the sticky bit
    function automatic logic [26:0] sh_sticky(input logic [26:0] x, input logic [8:0] sh);
        logic [26:0] mask;
        logic [26:0] y;
        if (sh >= 9'd27) begin
            return {26'd0, |x};
        end
        mask = ~({27{1'b1}} << sh);
        y    = x >> sh;
        return {y[26:1], y[0] | (|(x & mask))};
    endfunction

    // round to nearest even and pack; x holds mantissa, guard, round, sticky
    function automatic logic [31:0] round_pack(input logic s, input logic signed [9:0] e,
                                               input logic [26:0] x);
        logic              up;
        logic [24:0]       m;
        logic signed [9:0] ee;
        up = x[2] & (x[1] | x[0] | x[3]);
        m  = {1'b0, x[26:3]} + {24'd0, up};
        ee = e;
        if (m[24]) begin
            m  = m >> 1;
            ee = e + 10'sd1;
        end
        if (ee >= 10'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        if (!m[23]) begin
            return {s, 8'd0, m[22:0]};
        end
        return {s, ee[7:0], m[22:0]};
    endfunction

endpackage
`default_nettype wire

// ===== design/tabs_fpu.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tabs_fpu (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tabs_pkg::t_fpu_req i_req,
    output logic                    o_done,
    output logic [31:0]             o_result
);
    import tabs_pkg::*;

    localparam logic [3:0] F_IDLE   = 4'd0;
    localparam logic [3:0] F_ALIGN  = 4'd1;
    localparam logic [3:0] F_ADD    = 4'd2;
    localparam logic [3:0] F_NORM   = 4'd3;
    localparam logic [3:0] F_DNORM  = 4'd4;
    localparam logic [3:0] F_DITER  = 4'd5;
    localparam logic [3:0] F_DSHIFT = 4'd6;
    localparam logic [3:0] F_RND    = 4'd7;

    logic [3:0]        r_state, n_state;
    logic              r_sign, n_sign;
    logic              r_eff, n_eff;
    logic signed [9:0] r_exp, n_exp;
    logic [26:0]       r_ma, n_ma;
    logic [26:0]       r_mb, n_mb;
    logic [7:0]        r_dd, n_dd;
    logic [27:0]       r_sum, n_sum;
    logic [25:0]       r_q, n_q;
    logic [4:0]        r_cnt, n_cnt;
    logic [31:0]       r_res, n_res;
    logic              r_done, n_done;

    logic [31:0]       a, b;
    logic [7:0]        ee_a, ee_b;
    logic [23:0]       m_a, m_b;
    logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sb2;
    logic [27:0]       add_sum;
    logic [26:0]       div_diff;
    logic              div_ge;
    logic [26:0]       div_ext;
    logic signed [9:0] neg_exp;

    // unpack operands
    always_comb begin
        a      = i_req.a;
        b      = i_req.b;
        ee_a   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        ee_b   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        m_a    = {a[30:23] != 8'd0, a[22:0]};
        m_b    = {b[30:23] != 8'd0, b[22:0]};
        nan_a  = f_nan(a);
        nan_b  = f_nan(b);
        inf_a  = (a[30:0] == 31'h7F80_0000);
        inf_b  = (b[30:0] == 31'h7F80_0000);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        sb2    = ~b[31];
    end

    always_comb begin
        add_sum  = r_eff ? ({1'b0, r_ma} - {1'b0, r_mb}) : ({1'b0, r_ma} + {1'b0, r_mb});
        div_ge   = (r_ma >= r_mb);
        div_diff = r_ma - r_mb;
        div_ext  = {r_q, |r_ma};
        neg_exp  = 10'sd1 - r_exp;
    end

    // sequence one operation
    always_comb begin
        n_state = r_state;
        n_sign  = r_sign;
        n_eff   = r_eff;
        n_exp   = r_exp;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_dd    = r_dd;
        n_sum   = r_sum;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_done  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == OP_SUB) begin
                        if (nan_a || nan_b) begin
                            n_res  = QNAN;
                            n_done = 1'b1;
                        end else if (inf_a && inf_b) begin
                            n_res  = (a[31] == sb2) ? a : QNAN;
                            n_done = 1'b1;
                        end else if (inf_a) begin
                            n_res  = a;
                            n_done = 1'b1;
                        end else if (inf_b) begin
                            n_res  = {sb2, 8'hFF, 23'd0};
                            n_done = 1'b1;
                        end else begin
                            if (a[30:0] >= b[30:0]) begin
                                n_sign = a[31];
                                n_exp  = {2'b00, ee_a};
                                n_ma   = {m_a, 3'b000};
                                n_mb   = {m_b, 3'b000};
                                n_dd   = ee_a - ee_b;
                            end else begin
                                n_sign = sb2;
                                n_exp  = {2'b00, ee_b};
                                n_ma   = {m_b, 3'b000};
                                n_mb   = {m_a, 3'b000};
                                n_dd   = ee_b - ee_a;
                            end
                            n_eff   = a[31] ^ sb2;
                            n_state = F_ALIGN;
                        end
                    end else begin
                        n_sign = a[31] ^ b[31];
                        if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) begin
                            n_res  = QNAN;
                            n_done = 1'b1;
                        end else if (inf_a || zero_b) begin
                            n_res  = {a[31] ^ b[31], 8'hFF, 23'd0};
                            n_done = 1'b1;
                        end else if (zero_a || inf_b) begin
                            n_res  = {a[31] ^ b[31], 31'd0};
                            n_done = 1'b1;
                        end else begin
                            n_ma    = {3'b000, m_a};
                            n_mb    = {3'b000, m_b};
                            n_exp   = $signed({2'b00, ee_a}) - $signed({2'b00, ee_b}) + 10'sd127;
                            n_state = F_DNORM;
                        end
                    end
                end
            end
            F_ALIGN: begin
                n_mb    = sh_sticky(r_mb, {1'b0, r_dd});
                n_state = F_ADD;
            end
            F_ADD: begin
                if (add_sum[27]) begin
                    n_sum = {1'b0, add_sum[27:2], add_sum[1] | add_sum[0]};
                    n_exp = r_exp + 10'sd1;
                end else begin
                    n_sum = add_sum;
                end
                n_state = F_NORM;
            end
            F_NORM: begin
                // shift left one place a cycle until the leading one sits or the exponent is down to 1
                if (r_sum == 28'd0) begin
                    n_res   = {~r_eff & r_sign, 31'd0};
                    n_done  = 1'b1;
                    n_state = F_IDLE;
                end else if (!r_sum[26] && (r_exp > 10'sd1)) begin
                    n_sum = {r_sum[26:0], 1'b0};
                    n_exp = r_exp - 10'sd1;
                end else begin
                    n_state = F_RND;
                end
            end
            F_DNORM: begin
                if (!r_ma[23]) begin
                    n_ma  = {r_ma[25:0], 1'b0};
                    n_exp = r_exp - 10'sd1;
                end else if (!r_mb[23]) begin
                    n_mb  = {r_mb[25:0], 1'b0};
                    n_exp = r_exp + 10'sd1;
                end else begin
                    if (r_ma < r_mb) begin
                        n_ma  = {r_ma[25:0], 1'b0};
                        n_exp = r_exp - 10'sd1;
                    end
                    n_q     = 26'd0;
                    n_cnt   = 5'd0;
                    n_state = F_DITER;
                end
            end
            F_DITER: begin
                // one quotient bit a cycle
                n_ma  = div_ge ? {div_diff[25:0], 1'b0} : {r_ma[25:0], 1'b0};
                n_q   = {r_q[24:0], div_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd25) begin
                    n_state = F_DSHIFT;
                end
            end
            F_DSHIFT: begin
                if (r_exp < 10'sd1) begin
                    n_sum = {1'b0, sh_sticky(div_ext, neg_exp[8:0])};
                    n_exp = 10'sd1;
                end else begin
                    n_sum = {1'b0, div_ext};
                end
                n_state = F_RND;
            end
            F_RND: begin
                n_res   = round_pack(r_sign, r_exp, r_sum[26:0]);
                n_done  = 1'b1;
                n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_sign <= n_sign;
        r_eff  <= n_eff;
        r_exp  <= n_exp;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_dd   <= n_dd;
        r_sum  <= n_sum;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

// ===== design/tabs_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tabs_lane #(
    parameter int MAX_BREAKPOINTS = tabs_pkg::MAX_BREAKPOINTS_DEF,
    parameter int AW              = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [31:0]                i_wr_data,
    input  wire logic                       i_start,
    input  wire logic [tabs_pkg::CNT_W-1:0] i_count,
    input  wire logic [31:0]                i_value,
    output tabs_pkg::t_lane_res             o_res
);
    import tabs_pkg::*;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_HI   = 3'd1;
    localparam logic [2:0] L_LO   = 3'd2;
    localparam logic [2:0] L_SCAN = 3'd3;
    localparam logic [2:0] L_NUM  = 3'd4;
    localparam logic [2:0] L_DEN  = 3'd5;
    localparam logic [2:0] L_DIV  = 3'd6;

    localparam logic [8:0] MAX9 = 9'(MAX_BREAKPOINTS);

    logic [31:0]    r_mem [MAX_BREAKPOINTS];
    logic [31:0]    r_rd_a, r_rd_b;

    logic [2:0]     r_state, n_state;
    logic [31:0]    r_v, n_v;
    logic [AW-1:0]  r_last, n_last;
    logic [AW-1:0]  r_k, n_k;
    logic [31:0]    r_lo, n_lo;
    logic [31:0]    r_hi, n_hi;
    logic [31:0]    r_num, n_num;
    logic [AW-1:0]  r_idx, n_idx;
    logic [31:0]    r_frac, n_frac;
    logic           r_done, n_done;

    logic [AW-1:0]  rd_addr_a, rd_addr_b;
    logic [8:0]     cnt9, n9, last9;
    logic [AW-1:0]  kp1, kp2;
    logic           scan_end;
    logic [AW+4:0]  idx_ext;
    t_fpu_req       fpu_req;
    logic           fpu_done;
    logic [31:0]    fpu_res;

    tabs_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fpu_req),
        .o_done   (fpu_done),
        .o_result (fpu_res)
    );

    // clamp the count into 1..MAX
    always_comb begin
        cnt9 = {3'b000, i_count};
        if (cnt9 == 9'd0) begin
            n9 = 9'd1;
        end else if (cnt9 > MAX9) begin
            n9 = MAX9;
        end else begin
            n9 = cnt9;
        end
        last9    = n9 - 9'd1;
        kp1      = r_k + AW'(1);
        kp2      = r_k + AW'(2);
        scan_end = ({1'b0, r_k} + {{AW{1'b0}}, 1'b1}) >= {1'b0, r_last};
    end

    always_comb begin
        n_state   = r_state;
        n_v       = r_v;
        n_last    = r_last;
        n_k       = r_k;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_num     = r_num;
        n_idx     = r_idx;
        n_frac    = r_frac;
        n_done    = 1'b0;
        rd_addr_a = r_k;
        rd_addr_b = kp1;
        fpu_req   = '{start: 1'b0, op: OP_SUB, a: r_v, b: r_rd_a};
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_v       = i_value;
                    n_last    = last9[AW-1:0];
                    rd_addr_a = last9[AW-1:0];
                    n_state   = L_HI;
                end
            end
            L_HI: begin
                // not below the last breakpoint, NaN included: clamp high
                if (!f_lt(r_v, r_rd_a)) begin
                    n_idx   = r_last;
                    n_frac  = 32'd0;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end else begin
                    rd_addr_a = AW'(0);
                    n_state   = L_LO;
                end
            end
            L_LO: begin
                if (f_lt(r_v, r_rd_a)) begin
                    n_idx   = AW'(0);
                    n_frac  = 32'd0;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end else begin
                    n_k       = AW'(0);
                    rd_addr_a = AW'(0);
                    rd_addr_b = AW'(1);
                    n_state   = L_SCAN;
                end
            end
            L_SCAN: begin
                // test one interval a cycle
                if (f_le(r_rd_a, r_v) && f_lt(r_v, r_rd_b)) begin
                    n_lo          = r_rd_a;
                    n_hi          = r_rd_b;
                    n_idx         = r_k;
                    fpu_req.start = 1'b1;
                    n_state       = L_NUM;
                end else if (scan_end) begin
                    n_idx   = r_last;
                    n_frac  = 32'd0;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end else begin
                    n_k       = kp1;
                    rd_addr_a = kp1;
                    rd_addr_b = kp2;
                end
            end
            L_NUM: begin
                fpu_req.a = r_hi;
                fpu_req.b = r_lo;
                if (fpu_done) begin
                    n_num         = fpu_res;
                    fpu_req.start = 1'b1;
                    n_state       = L_DEN;
                end
            end
            L_DEN: begin
                fpu_req.op = OP_DIV;
                fpu_req.a  = r_num;
                fpu_req.b  = fpu_res;
                if (fpu_done) begin
                    if (fpu_res[30:0] == 31'd0) begin
                        n_frac  = 32'd0;
                        n_done  = 1'b1;
                        n_state = L_IDLE;
                    end else begin
                        fpu_req.start = 1'b1;
                        n_state       = L_DIV;
                    end
                end
            end
            L_DIV: begin
                if (fpu_done) begin
                    n_frac  = f_nan(fpu_res) ? QNAN : fpu_res;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    // breakpoint table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_v    <= n_v;
        r_last <= n_last;
        r_k    <= n_k;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_num  <= n_num;
        r_idx  <= n_idx;
        r_frac <= n_frac;
    end

    assign idx_ext        = {5'd0, r_idx};
    assign o_res.done     = r_done;
    assign o_res.index    = idx_ext[IDX_W-1:0];
    assign o_res.fraction = r_frac;

endmodule
`default_nettype wire

// ===== design/two_axis_breakpoint_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-axis breakpoint search. A load (req_type 0) writes one breakpoint in the
// cycle it is accepted and gives no result; busy stays low. A lookup raises busy
// and runs the x and y axes in two lanes side by side; the result appears for a
// single cycle on o_result_strobe once both lanes finish, and busy drops at that
// edge. The receiver cannot stall it, so sample it when the strobe is high.
// Per axis, a value clamped high finishes on the first table read and one
// clamped low on the second; otherwise an interval scan follows (one interval
// per cycle, up to the interval found), then two float subtractions (one
// normalising shift per cycle) and, unless the denominator is zero, a division
// (one quotient bit per cycle); the slower axis decides when the merge raises
// the strobe, and no new request is accepted until busy is low again. Count
// registers may be written only while busy is low.
module two_axis_breakpoint_search_core #(
    parameter int MAX_BREAKPOINTS = tabs_pkg::MAX_BREAKPOINTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_req_type,
    input  wire logic                       i_axis_sel,
    input  wire logic [tabs_pkg::POS_W-1:0] i_entry_index,
    input  wire logic [31:0]                i_entry_value,
    input  wire logic [31:0]                i_x_value,
    input  wire logic [31:0]                i_y_value,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic                       i_cfg_index,
    input  wire logic [tabs_pkg::CNT_W-1:0] i_cfg_data,
    output logic                            o_result_strobe,
    output logic [tabs_pkg::IDX_W-1:0]      o_x_index,
    output logic [tabs_pkg::IDX_W-1:0]      o_y_index,
    output logic [31:0]                     o_x_fraction,
    output logic [31:0]                     o_y_fraction
);
    import tabs_pkg::*;

    localparam int         AW   = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
    localparam logic [8:0] MAX9 = 9'(MAX_BREAKPOINTS);

    logic [CNT_W-1:0] r_x_count, r_y_count;
    logic             r_busy, n_busy;
    logic             r_x_fin, n_x_fin;
    logic             r_y_fin, n_y_fin;
    logic             r_strobe, n_strobe;
    logic [IDX_W-1:0] r_x_index, r_y_index;
    logic [31:0]      r_x_frac, r_y_frac;

    logic             accept, load, lookup, pos_ok;
    logic [AW+4:0]    pos_ext;
    t_lane_res        x_res, y_res;

    assign accept  = start && !r_busy;
    assign load    = accept && (i_req_type == REQ_LOAD);
    assign lookup  = accept && (i_req_type == REQ_LOOKUP);
    assign pos_ok  = ({4'd0, i_entry_index} < MAX9);
    assign pos_ext = {{AW{1'b0}}, i_entry_index};

    tabs_lane #(.MAX_BREAKPOINTS(MAX_BREAKPOINTS), .AW(AW)) u_x_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (load && pos_ok && (i_axis_sel == AXIS_X)),
        .i_wr_addr (pos_ext[AW-1:0]),
        .i_wr_data (i_entry_value),
        .i_start   (lookup),
        .i_count   (r_x_count),
        .i_value   (i_x_value),
        .o_res     (x_res)
    );

    tabs_lane #(.MAX_BREAKPOINTS(MAX_BREAKPOINTS), .AW(AW)) u_y_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (load && pos_ok && (i_axis_sel == AXIS_Y)),
        .i_wr_addr (pos_ext[AW-1:0]),
        .i_wr_data (i_entry_value),
        .i_start   (lookup),
        .i_count   (r_y_count),
        .i_value   (i_y_value),
        .o_res     (y_res)
    );

    // merge: wait for both lanes, then present one transaction
    always_comb begin
        n_busy   = r_busy;
        n_x_fin  = r_x_fin | x_res.done;
        n_y_fin  = r_y_fin | y_res.done;
        n_strobe = 1'b0;
        if (lookup) begin
            n_busy = 1'b1;
        end
        if (n_x_fin && n_y_fin) begin
            n_strobe = 1'b1;
            n_busy   = 1'b0;
            n_x_fin  = 1'b0;
            n_y_fin  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_x_fin   <= 1'b0;
            r_y_fin   <= 1'b0;
            r_strobe  <= 1'b0;
            r_x_count <= CNT_W'(1);
            r_y_count <= CNT_W'(1);
        end else begin
            r_busy   <= n_busy;
            r_x_fin  <= n_x_fin;
            r_y_fin  <= n_y_fin;
            r_strobe <= n_strobe;
            // take count writes
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_X_COUNT) begin
                    r_x_count <= i_cfg_data;
                end else begin
                    r_y_count <= i_cfg_data;
                end
            end
        end
        if (n_strobe) begin
            r_x_index <= x_res.index;
            r_y_index <= y_res.index;
            r_x_frac  <= x_res.fraction;
            r_y_frac  <= y_res.fraction;
        end
    end

    assign busy            = r_busy;
    assign o_cfg_ready     = 1'b1;
    assign o_result_strobe = r_strobe;
    assign o_x_index       = r_x_index;
    assign o_y_index       = r_y_index;
    assign o_x_fraction    = r_x_frac;
    assign o_y_fraction    = r_y_frac;

endmodule
`default_nettype wire

// ===== design/tabs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tabs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_req_type,
    input wire logic o_result_strobe
);
    import tabs_pkg::*;

    // a result only ever closes a lookup in flight
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without a pending lookup");

    // an accepted lookup holds the block busy
    a_lookup_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_LOOKUP)) |=> busy)
        else $error("lookup accepted but busy not raised");

    // a load never raises busy
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_LOAD)) |=> !busy)
        else $error("load raised busy");

    // results never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("two results in consecutive cycles");

endmodule

bind two_axis_breakpoint_search_core tabs_checker u_tabs_checker (.*);
`default_nettype wire

// ===== test/tb_two_axis_breakpoint_search_core.sv =====
`timescale 1ns / 1ps
module tb_two_axis_breakpoint_search_core;
    import tabs_pkg::*;

    typedef struct {
        logic        req;
        logic        axis;
        logic [4:0]  pos;
        logic [31:0] entry;
        logic [31:0] xv;
        logic [31:0] yv;
    } t_request;

    typedef struct {
        logic [4:0]  xi;
        logic [4:0]  yi;
        logic [31:0] xf;
        logic [31:0] yf;
    } t_interval;

    localparam logic [31:0] KEY_MIN = 32'h0080_0000;
    localparam logic [31:0] KEY_MAX = 32'hFF80_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        i_req_type = 1'b0;
    logic        i_axis_sel = 1'b0;
    logic [4:0]  i_entry_index = '0;
    logic [31:0] i_entry_value = '0;
    logic [31:0] i_x_value = '0;
    logic [31:0] i_y_value = '0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [5:0]  i_cfg_data = '0;
    logic        busy;
    logic        o_cfg_ready;
    logic        o_result_strobe;
    logic [4:0]  o_x_index;
    logic [4:0]  o_y_index;
    logic [31:0] o_x_fraction;
    logic [31:0] o_y_fraction;

    t_request    pending_requests[$];
    t_interval   expected_intervals[$];
    logic [31:0] x_table[32];
    logic [31:0] y_table[32];
    logic [31:0] plan_x[32];
    logic [31:0] plan_y[32];
    int          x_count = 1;
    int          y_count = 1;
    int          gap = 0;
    bit          idle_en = 1'b1;
    int          errors = 0;

    two_axis_breakpoint_search_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_axis_sel(i_axis_sel),
        .i_entry_index(i_entry_index), .i_entry_value(i_entry_value),
        .i_x_value(i_x_value), .i_y_value(i_y_value),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_result_strobe(o_result_strobe), .o_x_index(o_x_index),
        .o_y_index(o_y_index), .o_x_fraction(o_x_fraction),
        .o_y_fraction(o_y_fraction)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // widen a single bit pattern to a real, exactly
    function automatic real single_to_real(input logic [31:0] b);
        real r;
        if (b[30:23] == 8'hFF) begin
            return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
        end
        if (b[30:23] == 8'd0) begin
            r = real'(b[22:0]) * (2.0 ** (-149));
            return b[31] ? -r : r;
        end
        return $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0});
    endfunction

    // round a real to single precision, nearest even, NaN made canonical
    function automatic logic [31:0] round_single(input real r);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] packed_val;
        int          e;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 0) ? QNAN : {d[63], 8'hFF, 23'd0};
        end
        if (d[62:52] == 11'd0) begin
            return {d[63], 31'd0};
        end
        e = int'(d[62:52]) - 1023;
        if (e > 127) begin
            return {d[63], 8'hFF, 23'd0};
        end
        m = {11'd0, 1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60) sh = 60;
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        if (e >= -126) begin
            packed_val = (64'(e + 126) << 23) + q;
            if (packed_val >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
            return {d[63], packed_val[30:0]};
        end
        return {d[63], q[30:0]};
    endfunction

    // interval search and fraction for one axis
    function automatic void search_interval(input logic [31:0] tab[32], input int n,
                                            input logic [31:0] v,
                                            output logic [4:0] idx,
                                            output logic [31:0] frac);
        real rv;
        real lo;
        real hi;
        logic [31:0] num;
        logic [31:0] den;
        idx = 5'(n - 1);
        frac = '0;
        rv = single_to_real(v);
        if (!(rv < single_to_real(tab[n-1]))) return;
        if (rv < single_to_real(tab[0])) begin
            idx = '0;
            return;
        end
        for (int k = 0; k + 1 < n; k++) begin
            lo = single_to_real(tab[k]);
            hi = single_to_real(tab[k+1]);
            if (lo <= rv && rv < hi) begin
                num = round_single(rv - lo);
                den = round_single(hi - lo);
                idx = 5'(k);
                if (single_to_real(den) == 0.0) frac = '0;
                else frac = round_single(single_to_real(num) / single_to_real(den));
                return;
            end
        end
    endfunction

    function automatic logic [31:0] order_key(input logic [31:0] b);
        return b[31] ? ~b : {1'b1, b[30:0]};
    endfunction

    function automatic logic [31:0] key_to_single(input logic [31:0] k);
        return k[31] ? {1'b0, k[30:0]} : ~k;
    endfunction

    function automatic int clamp_count(input logic [5:0] c);
        if (c == 0) return 1;
        if (c > 32) return 32;
        return int'(c);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // drive: hold until accepted, then issue the next transaction or idle
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (gap > 0) begin
                gap <= gap - 1;
                start <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                r = pending_requests.pop_front();
                i_req_type <= r.req;
                i_axis_sel <= r.axis;
                i_entry_index <= r.pos;
                i_entry_value <= r.entry;
                i_x_value <= r.xv;
                i_y_value <= r.yv;
                start <= 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 18);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: track loads, predict lookups, check results
    always @(posedge i_clk) begin
        t_interval w;
        t_interval g;
        if (i_rst_n) begin
            if (start && !busy) begin
                if (i_req_type == REQ_LOAD) begin
                    if (i_axis_sel == AXIS_X) x_table[i_entry_index] = i_entry_value;
                    else y_table[i_entry_index] = i_entry_value;
                end else begin
                    search_interval(x_table, x_count, i_x_value, w.xi, w.xf);
                    search_interval(y_table, y_count, i_y_value, w.yi, w.yf);
                    expected_intervals.push_back(w);
                end
            end
            if (o_result_strobe) begin
                if (expected_intervals.size() == 0) begin
                    report("unexpected result", 32'(o_x_index), 32'd0);
                end else begin
                    g = expected_intervals.pop_front();
                    if (o_x_index != g.xi) report("x_index", 32'(o_x_index), 32'(g.xi));
                    if (o_y_index != g.yi) report("y_index", 32'(o_y_index), 32'(g.yi));
                    if (o_x_fraction != g.xf) report("x_fraction", o_x_fraction, g.xf);
                    if (o_y_fraction != g.yf) report("y_fraction", o_y_fraction, g.yf);
                end
            end
        end
    end

    task automatic push_load(input logic axis, input logic [4:0] pos, input logic [31:0] v);
        t_request r;
        r.req = REQ_LOAD;
        r.axis = axis;
        r.pos = pos;
        r.entry = v;
        r.xv = $urandom;
        r.yv = $urandom;
        if (axis == AXIS_X) plan_x[pos] = v;
        else plan_y[pos] = v;
        pending_requests.push_back(r);
    endtask

    task automatic push_lookup(input logic [31:0] xv, input logic [31:0] yv);
        t_request r;
        r.req = REQ_LOOKUP;
        r.axis = 1'($urandom);
        r.pos = 5'($urandom);
        r.entry = $urandom;
        r.xv = xv;
        r.yv = yv;
        pending_requests.push_back(r);
    endtask

    // wait out every pending transaction and result, sampled once the edge has settled
    task automatic drain();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || start || busy ||
               expected_intervals.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(input logic idx, input logic [5:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_X_COUNT) x_count = clamp_count(data);
        else y_count = clamp_count(data);
    endtask

    // non-decreasing table built by walking the ordering key
    task automatic fill_table(input logic axis, input int n);
        logic [32:0] k;
        int          step_max;
        case ($urandom_range(0, 3))
            0: step_max = 4;
            1: step_max = 1 << 10;
            2: step_max = 1 << 20;
            default: step_max = 1 << 23;
        endcase
        k = 33'($urandom_range(KEY_MIN, KEY_MAX));
        for (int i = 0; i < n; i++) begin
            if (k > 33'(KEY_MAX)) k = 33'(KEY_MAX);
            push_load(axis, 5'(i), key_to_single(k[31:0]));
            k = k + 33'($urandom_range(1, step_max));
        end
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] tab[32], input int n);
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] t;
        logic [32:0] d;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom;
        if (r < 30) return tab[$urandom_range(0, n - 1)];
        lo = 33'(order_key(tab[0]));
        hi = 33'(order_key(tab[n-1]));
        if (hi < lo) begin
            t = lo;
            lo = hi;
            hi = t;
        end
        d = (hi - lo) / 4 + 4;
        lo = (lo > 33'(KEY_MIN) + d) ? lo - d : 33'(KEY_MIN);
        hi = (hi + d < 33'(KEY_MAX)) ? hi + d : 33'(KEY_MAX);
        return key_to_single($urandom_range(lo[31:0], hi[31:0]));
    endfunction

    initial begin
        logic [31:0] specials[14];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7F7F_FFFF,
                     32'hFF7F_FFFF, 32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000,
                     32'h3FC0_0000, 32'h7FA0_0000};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full tables, widest counts, extremes and specials
        write_count(CFG_X_COUNT, 6'd32);
        write_count(CFG_Y_COUNT, 6'd32);
        fill_table(AXIS_X, 32);
        fill_table(AXIS_Y, 32);
        push_lookup(plan_x[0], plan_y[31]);
        push_lookup(plan_x[31], plan_y[0]);
        push_lookup(plan_x[15], plan_y[16]);
        for (int i = 0; i < 14; i++) push_lookup(specials[i], specials[13 - i]);
        drain();

        // single breakpoint, then counts that clamp
        write_count(CFG_X_COUNT, 6'd1);
        write_count(CFG_Y_COUNT, 6'd1);
        push_lookup(plan_x[0], 32'hFF80_0000);
        push_lookup(32'h7FC0_0000, plan_y[5]);
        drain();
        write_count(CFG_X_COUNT, 6'd0);
        write_count(CFG_Y_COUNT, 6'd63);
        push_lookup(plan_x[3], plan_y[31]);
        push_lookup(32'hFF7F_FFFF, plan_y[30]);
        drain();

        // a -inf breakpoint gives a NaN fraction; a NaN breakpoint finds no interval
        write_count(CFG_X_COUNT, 6'd4);
        write_count(CFG_Y_COUNT, 6'd3);
        push_load(AXIS_X, 5'd0, 32'hFF80_0000);
        push_load(AXIS_X, 5'd1, 32'hBF80_0000);
        push_load(AXIS_X, 5'd2, 32'h3F80_0000);
        push_load(AXIS_X, 5'd3, 32'h7F80_0000);
        push_load(AXIS_Y, 5'd0, 32'h0000_0000);
        push_load(AXIS_Y, 5'd1, 32'h7FC0_0000);
        push_load(AXIS_Y, 5'd2, 32'h4000_0000);
        push_lookup(32'hC0A0_0000, 32'h3F80_0000);
        push_lookup(32'h4000_0000, 32'h0000_0000);
        push_lookup(32'h0000_0000, 32'h8000_0000);
        drain();

        // random phases: new counts, refreshed tables, lookups with some stray loads
        for (int ph = 0; ph < 8; ph++) begin
            int xn;
            int yn;
            idle_en = (ph < 6);
            xn = (ph == 1) ? 32 : (ph == 2) ? 1 : $urandom_range(1, 32);
            yn = (ph == 2) ? 32 : (ph == 3) ? 1 : $urandom_range(1, 32);
            write_count(CFG_X_COUNT, 6'(xn));
            write_count(CFG_Y_COUNT, 6'(yn));
            fill_table(AXIS_X, xn);
            fill_table(AXIS_Y, yn);
            for (int i = 0; i < 60; i++) begin
                if ($urandom_range(0, 9) == 0)
                    push_load(1'($urandom), 5'($urandom), $urandom);
                else
                    push_lookup(pick_value(plan_x, x_count), pick_value(plan_y, y_count));
            end
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_two_axis_breakpoint_search_core OK");
        end else begin
            $display("tb_two_axis_breakpoint_search_core NOT OK");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_two_axis_breakpoint_search_core NOT OK");
        $finish;
    end

endmodule
